// ===== design/gbfp_pkg.sv =====
package gbfp_pkg;

  localparam int unsigned PAYLOAD_BYTES_DEF = 128;

  localparam logic [7:0] SYNC_FIRST     = 8'hB5;
  localparam logic [7:0] SYNC_SECOND    = 8'h62;
  localparam logic [7:0] MAX_LENGTH_RST = 8'd92;
  localparam logic [7:0] LENGTH_SAT     = 8'hFF;

  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_READ = 1'b1;

  localparam logic [2:0] READ_SIZE_BYTE = 3'd1;
  localparam logic [2:0] READ_SIZE_HALF = 3'd2;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic        REG_MAX_LENGTH = 1'b0;

  typedef enum logic [3:0] {
    PH_HUNT,
    PH_SYNC1,
    PH_CLASS,
    PH_ID,
    PH_LEN1,
    PH_LEN2,
    PH_PAYLOAD,
    PH_CKA,
    PH_CKB
  } phase_e;

  typedef struct packed {
    logic       ok;
    logic [7:0] cls;
    logic [7:0] id;
    logic [7:0] len;
  } frame_info_t;

  typedef struct packed {
    logic        frame_ok;
    logic [7:0]  frame_class;
    logic [7:0]  frame_id;
    logic [7:0]  frame_length;
    logic        read_valid;
    logic [31:0] read_value;
  } result_t;

endpackage

// ===== design/gbfp_in_if.sv =====
interface gbfp_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] data_byte;
  logic [6:0] read_offset;
  logic [2:0] read_size;
  logic       read_signed;

  modport source (
    output valid, action, data_byte, read_offset, read_size, read_signed,
    input  ready
  );

  modport sink (
    input  valid, action, data_byte, read_offset, read_size, read_signed,
    output ready
  );
endinterface

// ===== design/gbfp_out_if.sv =====
interface gbfp_out_if;
  logic        valid;
  logic        ready;
  logic        frame_ok;
  logic [7:0]  frame_class;
  logic [7:0]  frame_id;
  logic [7:0]  frame_length;
  logic        read_valid;
  logic [31:0] read_value;

  modport source (
    output valid, frame_ok, frame_class, frame_id, frame_length, read_valid, read_value,
    input  ready
  );

  modport sink (
    input  valid, frame_ok, frame_class, frame_id, frame_length, read_valid, read_value,
    output ready
  );
endinterface

// ===== design/gbfp_apb_regs.sv =====
module gbfp_apb_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [gbfp_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [gbfp_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [gbfp_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready,
  output logic [7:0]                        max_length_o
);

  logic [7:0] max_length_q;
  logic       reg_idx;
  logic       wr_hit;

  assign reg_idx = paddr[gbfp_pkg::APB_ADDR_W-1];
  assign wr_hit  = psel && penable && pwrite && (reg_idx == gbfp_pkg::REG_MAX_LENGTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_length_q <= gbfp_pkg::MAX_LENGTH_RST;
    end else if (wr_hit) begin
      max_length_q <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == gbfp_pkg::REG_MAX_LENGTH) begin
      prdata = {{(gbfp_pkg::APB_DATA_W-8){1'b0}}, max_length_q};
    end
  end

  assign pready       = 1'b1;
  assign max_length_o = max_length_q;

endmodule

// ===== design/gbfp_parser.sv =====
module gbfp_parser #(
  parameter int unsigned PAYLOAD_BYTES = gbfp_pkg::PAYLOAD_BYTES_DEF,
  localparam int unsigned ADDR_W = $clog2(PAYLOAD_BYTES)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  byte_en_i,
  input  logic [7:0]            data_byte_i,
  input  logic [7:0]            max_length_i,
  output gbfp_pkg::frame_info_t info_o,
  output logic                  wr_en_o,
  output logic [ADDR_W-1:0]     wr_addr_o,
  output logic [7:0]            wr_data_o
);

  localparam int unsigned CNT_W = $clog2(PAYLOAD_BYTES + 1);

  gbfp_pkg::phase_e phase_q, phase_d;
  logic [7:0]       class_q, class_d;
  logic [7:0]       id_q, id_d;
  logic [15:0]      length_q, length_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [7:0]       sum_a_q, sum_a_d;
  logic [7:0]       sum_b_q, sum_b_d;

  logic [7:0]       sum_a_add;
  logic [7:0]       sum_b_add;
  logic [15:0]      len_full;
  logic [CNT_W-1:0] count_inc;
  logic             ok;

  assign sum_a_add = sum_a_q + data_byte_i;
  assign sum_b_add = sum_b_q + sum_a_add;
  assign len_full  = {data_byte_i, length_q[7:0]};
  assign count_inc = count_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= gbfp_pkg::PH_HUNT;
      class_q  <= '0;
      id_q     <= '0;
      length_q <= '0;
      count_q  <= '0;
      sum_a_q  <= '0;
      sum_b_q  <= '0;
    end else begin
      phase_q  <= phase_d;
      class_q  <= class_d;
      id_q     <= id_d;
      length_q <= length_d;
      count_q  <= count_d;
      sum_a_q  <= sum_a_d;
      sum_b_q  <= sum_b_d;
    end
  end

  always_comb begin
    phase_d  = phase_q;
    class_d  = class_q;
    id_d     = id_q;
    length_d = length_q;
    count_d  = count_q;
    sum_a_d  = sum_a_q;
    sum_b_d  = sum_b_q;
    ok       = 1'b0;
    wr_en_o  = 1'b0;
    if (byte_en_i) begin
      case (phase_q)
        gbfp_pkg::PH_HUNT: begin
          if (data_byte_i == gbfp_pkg::SYNC_FIRST) phase_d = gbfp_pkg::PH_SYNC1;
        end
        gbfp_pkg::PH_SYNC1: begin
          if (data_byte_i == gbfp_pkg::SYNC_SECOND) begin
            phase_d = gbfp_pkg::PH_CLASS;
            sum_a_d = '0;
            sum_b_d = '0;
          end else begin
            phase_d = gbfp_pkg::PH_HUNT;
          end
        end
        gbfp_pkg::PH_CLASS: begin
          class_d = data_byte_i;
          sum_a_d = sum_a_add;
          sum_b_d = sum_b_add;
          phase_d = gbfp_pkg::PH_ID;
        end
        gbfp_pkg::PH_ID: begin
          id_d    = data_byte_i;
          sum_a_d = sum_a_add;
          sum_b_d = sum_b_add;
          phase_d = gbfp_pkg::PH_LEN1;
        end
        gbfp_pkg::PH_LEN1: begin
          length_d = {8'h00, data_byte_i};
          sum_a_d  = sum_a_add;
          sum_b_d  = sum_b_add;
          phase_d  = gbfp_pkg::PH_LEN2;
        end
        gbfp_pkg::PH_LEN2: begin
          length_d = len_full;
          if (len_full <= {8'h00, max_length_i}) begin
            sum_a_d = sum_a_add;
            sum_b_d = sum_b_add;
            count_d = '0;
            phase_d = (len_full == 16'h0000) ? gbfp_pkg::PH_CKA : gbfp_pkg::PH_PAYLOAD;
          end else begin
            phase_d = gbfp_pkg::PH_HUNT;
          end
        end
        gbfp_pkg::PH_PAYLOAD: begin
          if (count_q < CNT_W'(PAYLOAD_BYTES)) begin
            sum_a_d = sum_a_add;
            sum_b_d = sum_b_add;
            wr_en_o = 1'b1;
            count_d = count_inc;
            if (16'(count_inc) == length_q) phase_d = gbfp_pkg::PH_CKA;
          end else begin
            phase_d = gbfp_pkg::PH_HUNT;
          end
        end
        gbfp_pkg::PH_CKA: begin
          phase_d = (data_byte_i == sum_a_q) ? gbfp_pkg::PH_CKB : gbfp_pkg::PH_HUNT;
        end
        gbfp_pkg::PH_CKB: begin
          phase_d = gbfp_pkg::PH_HUNT;
          ok      = (data_byte_i == sum_b_q);
        end
        default: phase_d = gbfp_pkg::PH_HUNT;
      endcase
    end
  end

  assign wr_addr_o = count_q[ADDR_W-1:0];
  assign wr_data_o = data_byte_i;

  assign info_o.ok  = ok;
  assign info_o.cls = class_d;
  assign info_o.id  = id_d;
  assign info_o.len = (|length_d[15:8]) ? gbfp_pkg::LENGTH_SAT : length_d[7:0];

endmodule

// ===== design/gbfp_payload_mem.sv =====
module gbfp_payload_mem #(
  parameter int unsigned PAYLOAD_BYTES = gbfp_pkg::PAYLOAD_BYTES_DEF,
  localparam int unsigned ADDR_W = $clog2(PAYLOAD_BYTES)
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [7:0]        wr_data_i,
  input  logic              rd_en_i,
  input  logic [6:0]        rd_offset_i,
  output logic [3:0][7:0]   rd_bytes_o
);

  localparam int unsigned BANKS = 4;
  localparam int unsigned ROW_W = ADDR_W - 2;
  localparam int unsigned ROWS  = (PAYLOAD_BYTES + BANKS - 1) / BANKS;

  logic [ROW_W-1:0] wr_row;
  logic [ROW_W-1:0] rd_row [BANKS];
  logic             rd_hit [BANKS];
  logic [7:0]       rd_q   [BANKS];
  logic             hit_q  [BANKS];
  logic [1:0]       off_q;

  assign wr_row = wr_addr_i[ADDR_W-1:2];

  // each bank holds every fourth byte, so a four byte field touches each bank once
  always_comb begin
    for (int b = 0; b < BANKS; b++) begin
      logic [1:0] lane;
      logic [7:0] idx;
      lane      = 2'(b) - rd_offset_i[1:0];
      idx       = {1'b0, rd_offset_i} + {6'b0, lane};
      rd_row[b] = ROW_W'(idx[7:2]);
      rd_hit[b] = (32'(idx) < PAYLOAD_BYTES);
    end
  end

  for (genvar g = 0; g < BANKS; g++) begin : g_bank
    logic [7:0] bank_mem [ROWS];

    always_ff @(posedge clk_i) begin
      if (wr_en_i && (wr_addr_i[1:0] == 2'(g))) begin
        bank_mem[wr_row] <= wr_data_i;
      end
      if (rd_en_i) begin
        rd_q[g]  <= bank_mem[rd_row[g]];
        hit_q[g] <= rd_hit[g];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) off_q <= rd_offset_i[1:0];
  end

  always_comb begin
    for (int k = 0; k < BANKS; k++) begin
      logic [1:0] bsel;
      bsel          = off_q + 2'(k);
      rd_bytes_o[k] = hit_q[bsel] ? rd_q[bsel] : 8'h00;
    end
  end

endmodule

// ===== design/gbfp_field_ext.sv =====
module gbfp_field_ext (
  input  logic [3:0][7:0] bytes_i,
  input  logic [2:0]      size_i,
  input  logic            sgn_i,
  output logic [31:0]     value_o
);

  always_comb begin
    case (size_i) inside
      [3'd0:gbfp_pkg::READ_SIZE_BYTE]: value_o = {{24{sgn_i & bytes_i[0][7]}}, bytes_i[0]};
      gbfp_pkg::READ_SIZE_HALF: value_o = {{16{sgn_i & bytes_i[1][7]}}, bytes_i[1], bytes_i[0]};
      default: value_o = {bytes_i[3], bytes_i[2], bytes_i[1], bytes_i[0]};
    endcase
  end

endmodule

// ===== design/gnss_binary_frame_parser.sv =====
// each item passes the input, middle and result registers before its result is valid
// throughput: one item per cycle while out_o.ready holds, stream byte or field read alike
// the payload buffer is four byte-interleaved banks with a registered read,
// which sets the stage between the input and result registers
// reset clears parser state and pipeline valids, max_length returns to 92;
// the payload buffer is not cleared
module gnss_binary_frame_parser #(
  parameter int unsigned PAYLOAD_BYTES = gbfp_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  gbfp_in_if.sink                         in_i,
  gbfp_out_if.source                      out_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [gbfp_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [gbfp_pkg::APB_DATA_W-1:0] pwdata,
  output logic [gbfp_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  localparam int unsigned ADDR_W = $clog2(PAYLOAD_BYTES);

  logic [7:0] max_length;

  logic       en_in, en_mid, en_out;

  logic       in_v_q;
  logic       in_act_q;
  logic [7:0] in_data_q;
  logic [6:0] in_off_q;
  logic [2:0] in_size_q;
  logic       in_sgn_q;

  logic                  byte_en;
  gbfp_pkg::frame_info_t info;
  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_addr;
  logic [7:0]            wr_data;

  logic                  mid_v_q;
  gbfp_pkg::frame_info_t mid_info_q;
  logic                  mid_rvalid_q;
  logic [2:0]            mid_size_q;
  logic                  mid_sgn_q;
  logic [3:0][7:0]       rd_bytes;
  logic [31:0]           field_value;

  logic                  out_v_q;
  gbfp_pkg::result_t     out_q;

  gbfp_apb_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .max_length_o (max_length)
  );

  assign en_out   = !out_v_q || out_o.ready;
  assign en_mid   = !mid_v_q || en_out;
  assign en_in    = !in_v_q || en_mid;
  assign in_i.ready = en_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      mid_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (en_in)  in_v_q  <= in_i.valid;
      if (en_mid) mid_v_q <= in_v_q;
      if (en_out) out_v_q <= mid_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_in && in_i.valid) begin
      in_act_q  <= in_i.action;
      in_data_q <= in_i.data_byte;
      in_off_q  <= in_i.read_offset;
      in_size_q <= in_i.read_size;
      in_sgn_q  <= in_i.read_signed;
    end
  end

  assign byte_en = in_v_q && en_mid && (in_act_q == gbfp_pkg::ACT_BYTE);

  gbfp_parser #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_en_i    (byte_en),
    .data_byte_i  (in_data_q),
    .max_length_i (max_length),
    .info_o       (info),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data)
  );

  gbfp_payload_mem #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_mem (
    .clk_i       (clk_i),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (wr_data),
    .rd_en_i     (en_mid),
    .rd_offset_i (in_off_q),
    .rd_bytes_o  (rd_bytes)
  );

  always_ff @(posedge clk_i) begin
    if (en_mid && in_v_q) begin
      mid_info_q   <= info;
      mid_rvalid_q <= (in_act_q == gbfp_pkg::ACT_READ);
      mid_size_q   <= in_size_q;
      mid_sgn_q    <= in_sgn_q;
    end
  end

  gbfp_field_ext u_ext (
    .bytes_i (rd_bytes),
    .size_i  (mid_size_q),
    .sgn_i   (mid_sgn_q),
    .value_o (field_value)
  );

  always_ff @(posedge clk_i) begin
    if (en_out && mid_v_q) begin
      out_q.frame_ok     <= mid_info_q.ok;
      out_q.frame_class  <= mid_info_q.cls;
      out_q.frame_id     <= mid_info_q.id;
      out_q.frame_length <= mid_info_q.len;
      out_q.read_valid   <= mid_rvalid_q;
      out_q.read_value   <= mid_rvalid_q ? field_value : 32'h0000_0000;
    end
  end

  assign out_o.valid        = out_v_q;
  assign out_o.frame_ok     = out_q.frame_ok;
  assign out_o.frame_class  = out_q.frame_class;
  assign out_o.frame_id     = out_q.frame_id;
  assign out_o.frame_length = out_q.frame_length;
  assign out_o.read_valid   = out_q.read_valid;
  assign out_o.read_value   = out_q.read_value;

  a_ok_not_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_q.frame_ok |-> !out_q.read_valid)
    else $error("frame_ok raised on a read result");

  a_wr_from_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> in_v_q && en_mid && (in_act_q == gbfp_pkg::ACT_BYTE))
    else $error("payload write without a moving stream byte");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_v_q |-> in_i.ready)
    else $error("input stalled with an empty result register");

  a_mid_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_v_q && en_out |=> out_v_q)
    else $error("result lost between stages");

endmodule

// ===== tb/gbfp_checker.sv =====
module gbfp_checker
  import gbfp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic                  action_i,
  input  logic [7:0]            data_byte_i,
  input  logic [6:0]            read_offset_i,
  input  logic [2:0]            read_size_i,
  input  logic                  read_signed_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic                  frame_ok_i,
  input  logic [7:0]            frame_class_i,
  input  logic [7:0]            frame_id_i,
  input  logic [7:0]            frame_length_i,
  input  logic                  read_valid_i,
  input  logic [31:0]           read_value_i,
  input  logic                  psel_i,
  input  logic                  penable_i,
  input  logic                  pwrite_i,
  input  logic [APB_ADDR_W-1:0] paddr_i,
  input  logic [APB_DATA_W-1:0] pwdata_i,
  input  logic                  pready_i,
  output int                    errors_o,
  output int                    pending_o,
  output int                    good_frames_o,
  output int                    field_reads_o
);
  timeunit 1ns;
  timeprecision 1ps;

  phase_e      phase_q;
  logic [7:0]  class_q;
  logic [7:0]  id_q;
  logic [15:0] length_q;
  logic [7:0]  count_q;
  logic [7:0]  sum_a_q;
  logic [7:0]  sum_b_q;
  logic [7:0]  max_len_q;
  logic [7:0]  payload_q [PAYLOAD_BYTES_DEF];

  result_t expected_results [$];
  int      mismatches;
  int      pending;
  int      good_frames;
  int      field_reads;

  assign errors_o      = mismatches;
  assign pending_o     = pending;
  assign good_frames_o = good_frames;
  assign field_reads_o = field_reads;

  function automatic void add_checksum(input logic [7:0] b);
    sum_a_q = sum_a_q + b;
    sum_b_q = sum_b_q + sum_a_q;
  endfunction

  function automatic logic parse_byte(input logic [7:0] b);
    logic ok;
    ok = 1'b0;
    case (phase_q)
      PH_HUNT: begin
        if (b == SYNC_FIRST) phase_q = PH_SYNC1;
      end
      PH_SYNC1: begin
        if (b == SYNC_SECOND) begin
          phase_q = PH_CLASS;
          sum_a_q = '0;
          sum_b_q = '0;
        end else begin
          phase_q = PH_HUNT;
        end
      end
      PH_CLASS: begin
        class_q = b;
        add_checksum(b);
        phase_q = PH_ID;
      end
      PH_ID: begin
        id_q = b;
        add_checksum(b);
        phase_q = PH_LEN1;
      end
      PH_LEN1: begin
        length_q = {8'h00, b};
        add_checksum(b);
        phase_q = PH_LEN2;
      end
      PH_LEN2: begin
        length_q = {b, length_q[7:0]};
        if (length_q <= {8'h00, max_len_q}) begin
          add_checksum(b);
          count_q = '0;
          phase_q = (length_q == '0) ? PH_CKA : PH_PAYLOAD;
        end else begin
          phase_q = PH_HUNT;
        end
      end
      PH_PAYLOAD: begin
        if (count_q < PAYLOAD_BYTES_DEF) begin
          add_checksum(b);
          payload_q[count_q[6:0]] = b;
          count_q = count_q + 8'd1;
          if ({8'h00, count_q} == length_q) phase_q = PH_CKA;
        end else begin
          phase_q = PH_HUNT;
        end
      end
      PH_CKA: begin
        phase_q = (b == sum_a_q) ? PH_CKB : PH_HUNT;
      end
      PH_CKB: begin
        phase_q = PH_HUNT;
        ok = (b == sum_b_q);
      end
      default: begin
        phase_q = PH_HUNT;
      end
    endcase
    return ok;
  endfunction

  function automatic logic [31:0] field_value(input logic [6:0] offset, input logic [2:0] size,
                                              input logic sgn);
    int          n;
    int          idx;
    logic [31:0] v;
    if (size <= READ_SIZE_BYTE) n = 1;
    else if (size == READ_SIZE_HALF) n = 2;
    else n = 4;
    v = '0;
    for (int k = 0; k < n; k++) begin
      idx = offset + k;
      if (idx < PAYLOAD_BYTES_DEF) v[8*k +: 8] = payload_q[idx[6:0]];
    end
    if (sgn && n == 1 && v[7]) v[31:8] = '1;
    if (sgn && n == 2 && v[15]) v[31:16] = '1;
    return v;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] seen);
    if (want !== seen) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, seen);
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    result_t want;
    if (!rst_ni) begin
      phase_q     = PH_HUNT;
      class_q     = '0;
      id_q        = '0;
      length_q    = '0;
      count_q     = '0;
      sum_a_q     = '0;
      sum_b_q     = '0;
      max_len_q   = MAX_LENGTH_RST;
      mismatches  = 0;
      pending     = 0;
      good_frames = 0;
      field_reads = 0;
      expected_results.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i &&
          paddr_i == {REG_MAX_LENGTH, 2'b00}) begin
        max_len_q = pwdata_i[7:0];
      end

      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result transfer with nothing expected", $realtime);
          end
        end else begin
          want = expected_results.pop_front();
          pending--;
          check_field("frame_ok", 32'(want.frame_ok), 32'(frame_ok_i));
          check_field("frame_class", 32'(want.frame_class), 32'(frame_class_i));
          check_field("frame_id", 32'(want.frame_id), 32'(frame_id_i));
          check_field("frame_length", 32'(want.frame_length), 32'(frame_length_i));
          check_field("read_valid", 32'(want.read_valid), 32'(read_valid_i));
          check_field("read_value", want.read_value, read_value_i);
        end
      end

      if (in_valid_i && in_ready_i) begin
        want.frame_ok   = 1'b0;
        want.read_valid = 1'b0;
        want.read_value = '0;
        if (action_i == ACT_BYTE) begin
          want.frame_ok = parse_byte(data_byte_i);
          if (want.frame_ok) good_frames++;
        end else begin
          want.read_valid = 1'b1;
          want.read_value = field_value(read_offset_i, read_size_i, read_signed_i);
          field_reads++;
        end
        want.frame_class  = class_q;
        want.frame_id     = id_q;
        want.frame_length = (length_q > 16'd255) ? LENGTH_SAT : length_q[7:0];
        expected_results.push_back(want);
        pending++;
      end
    end
  end

endmodule

// ===== tb/tb_gnss_binary_frame_parser.sv =====
module tb_gnss_binary_frame_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import gbfp_pkg::*;

  localparam int         HOLD_CYCLES    = 300;
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         DRAIN_CYCLES   = 8;
  localparam logic [7:0] MAX_LENGTH_TOP = 8'hFF;

  typedef enum int {
    FRM_GOOD,
    FRM_BAD_CKA,
    FRM_BAD_CKB,
    FRM_CUT,
    FRM_LONG
  } frame_kind_e;

  logic clk = 1'b0;
  logic rst_n;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  gbfp_in_if  in_bus ();
  gbfp_out_if out_bus ();

  int errors;
  int pending;
  int good_frames;
  int field_reads;

  int         items_sent;
  int         settings;
  int         stall;
  logic [7:0] max_len_set;
  bit         src_idle_en;
  bit         snk_idle_en;
  bit         quiet;
  bit         hold_pending;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  gnss_binary_frame_parser u_top (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  gbfp_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_bus.valid),
    .in_ready_i     (in_bus.ready),
    .action_i       (in_bus.action),
    .data_byte_i    (in_bus.data_byte),
    .read_offset_i  (in_bus.read_offset),
    .read_size_i    (in_bus.read_size),
    .read_signed_i  (in_bus.read_signed),
    .out_valid_i    (out_bus.valid),
    .out_ready_i    (out_bus.ready),
    .frame_ok_i     (out_bus.frame_ok),
    .frame_class_i  (out_bus.frame_class),
    .frame_id_i     (out_bus.frame_id),
    .frame_length_i (out_bus.frame_length),
    .read_valid_i   (out_bus.read_valid),
    .read_value_i   (out_bus.read_value),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .pready_i       (pready),
    .errors_o       (errors),
    .pending_o      (pending),
    .good_frames_o  (good_frames),
    .field_reads_o  (field_reads)
  );

  function automatic logic [15:0] fletcher_next(input logic [15:0] sums, input logic [7:0] b);
    logic [7:0] a;
    logic [7:0] s;
    a = sums[15:8] + b;
    s = sums[7:0] + a;
    return {a, s};
  endfunction

  task automatic send_item(input logic act, input logic [7:0] data, input logic [6:0] offset,
                           input logic [2:0] size, input logic sgn);
    @(negedge clk);
    if (src_idle_en && $urandom_range(0, 7) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.action      <= act;
    in_bus.data_byte   <= data;
    in_bus.read_offset <= offset;
    in_bus.read_size   <= size;
    in_bus.read_signed <= sgn;
    do @(posedge clk); while (!in_bus.ready);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(ACT_BYTE, b, 7'($urandom), 3'($urandom), 1'($urandom));
  endtask

  task automatic send_read(input logic [6:0] offset, input logic [2:0] size, input logic sgn);
    send_item(ACT_READ, 8'($urandom), offset, size, sgn);
  endtask

  task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                            input logic [15:0] len, input frame_kind_e kind);
    logic [15:0] sums;
    logic [7:0]  b;
    int          cut_at;
    sums = '0;
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_byte(cls);
    sums = fletcher_next(sums, cls);
    send_byte(id);
    sums = fletcher_next(sums, id);
    send_byte(len[7:0]);
    sums = fletcher_next(sums, len[7:0]);
    send_byte(len[15:8]);
    sums = fletcher_next(sums, len[15:8]);
    if (kind == FRM_LONG) begin
      repeat ($urandom_range(0, 4)) send_byte(8'($urandom));
    end else begin
      cut_at = (kind == FRM_CUT) ? $urandom_range(0, len) : len;
      for (int k = 0; k < cut_at; k++) begin
        b = 8'($urandom);
        send_byte(b);
        sums = fletcher_next(sums, b);
      end
      if (kind != FRM_CUT) begin
        b = sums[15:8];
        if (kind == FRM_BAD_CKA) b = b ^ 8'($urandom_range(1, 255));
        send_byte(b);
        b = sums[7:0];
        if (kind == FRM_BAD_CKB) b = b ^ 8'($urandom_range(1, 255));
        send_byte(b);
      end
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_length(input logic [7:0] value);
    wait_idle();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_MAX_LENGTH, 2'b00};
    pwdata  <= APB_DATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    max_len_set = value;
    settings++;
  endtask

  task automatic run_mix(input int n);
    int          target;
    int          pick;
    int          hi;
    logic [15:0] len;
    frame_kind_e kind;
    target = items_sent + n;
    while (items_sent < target) begin
      if ($urandom_range(0, 39) == 0 && !quiet) begin
        src_idle_en = ($urandom_range(0, 3) != 0);
        snk_idle_en = ($urandom_range(0, 3) != 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        if (pick < 50) kind = FRM_GOOD;
        else if (pick < 58) kind = FRM_BAD_CKA;
        else if (pick < 65) kind = FRM_BAD_CKB;
        else if (pick < 70) kind = FRM_CUT;
        else kind = FRM_LONG;
        hi = (max_len_set < PAYLOAD_BYTES_DEF) ? max_len_set : PAYLOAD_BYTES_DEF;
        if (kind == FRM_LONG) len = 16'(max_len_set + 1 + $urandom_range(0, 400));
        else if ($urandom_range(0, 7) == 0) len = 16'($urandom_range(0, hi));
        else len = 16'($urandom_range(0, (hi > 16) ? 16 : hi));
        send_frame(8'($urandom), 8'($urandom), len, kind);
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 4)) begin
          send_read(($urandom_range(0, 3) == 0) ? 7'($urandom_range(120, 127)) : 7'($urandom),
                    3'($urandom), 1'($urandom));
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_byte(($urandom_range(0, 2) == 0) ? SYNC_FIRST : 8'($urandom));
        end
      end
    end
  endtask

  // output side backpressure
  initial begin
    out_bus.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_bus.ready <= 1'b1;
      end else if (snk_idle_en && $urandom_range(0, 7) == 0) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        out_bus.ready <= 1'b1;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  initial begin
    stall = 0;
    while (stall < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) stall = 0;
      else stall++;
    end
    $display("watchdog: no transfer for %0d cycles, %0d results outstanding", stall, pending);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    rst_n              = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    in_bus.valid       = 1'b0;
    in_bus.action      = ACT_BYTE;
    in_bus.data_byte   = '0;
    in_bus.read_offset = '0;
    in_bus.read_size   = '0;
    in_bus.read_signed = 1'b0;
    items_sent         = 0;
    settings           = 0;
    max_len_set        = MAX_LENGTH_RST;
    src_idle_en        = 1'b1;
    snk_idle_en        = 1'b1;
    quiet              = 1'b0;
    hold_pending       = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // fill the whole payload buffer so that later reads never hit unwritten bytes
    write_max_length(8'(PAYLOAD_BYTES_DEF));
    send_frame(8'($urandom), 8'($urandom), 16'(PAYLOAD_BYTES_DEF), FRM_GOOD);

    // zero-length frame, straight to the check bytes
    send_frame(8'hFF, 8'h00, 16'd0, FRM_GOOD);
    // second sync byte wrong, it is not retried as a first sync
    send_byte(SYNC_FIRST);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_byte(8'h00);
    // field reads: every size code, both extensions, past the buffer end
    send_read(7'd0, READ_SIZE_BYTE, 1'b1);
    send_read(7'd0, 3'd0, 1'b0);
    send_read(7'd127, 3'd4, 1'b0);
    send_read(7'd126, READ_SIZE_HALF, 1'b1);
    send_read(7'd125, 3'd3, 1'b1);
    send_read(7'd64, 3'd7, 1'b1);
    send_read(7'd1, 3'd5, 1'b0);
    send_read(7'd2, 3'd6, 1'b1);
    send_read(7'd127, READ_SIZE_BYTE, 1'b1);
    send_byte(8'hFF);

    hold_pending = 1'b1;
    run_mix(220);

    write_max_length(8'd0);
    run_mix(130);

    write_max_length(8'($urandom_range(1, 127)));
    run_mix(220);

    // length fits the register but overruns the buffer
    write_max_length(MAX_LENGTH_TOP);
    send_frame(8'($urandom), 8'($urandom), 16'(PAYLOAD_BYTES_DEF + 2), FRM_GOOD);
    run_mix(50);

    write_max_length(MAX_LENGTH_RST);
    quiet       = 1'b1;
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    run_mix(220);

    wait_idle();
    $display("covered %0d input transfers, %0d good frames, %0d field reads, %0d max_length writes",
             items_sent, good_frames, field_reads, settings);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/gbfp_pkg.sv
design/gbfp_in_if.sv
design/gbfp_out_if.sv
design/gbfp_apb_regs.sv
design/gbfp_parser.sv
design/gbfp_payload_mem.sv
design/gbfp_field_ext.sv
design/gnss_binary_frame_parser.sv
tb/gbfp_checker.sv
tb/tb_gnss_binary_frame_parser.sv
